>>> sv/lsmt_pkg.sv
// Shared types, codes and default sizes of the LCD scanline mode timer.
package lsmt_pkg;

  localparam int DotsPerLineDef     = 456;
  localparam int VisibleLinesDef    = 144;
  localparam int TotalLinesDef      = 154;
  localparam int OamDotsDef         = 80;
  localparam int TransferMinDotsDef = 172;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [7:0] line;
    mode_e      mode;
    logic       lyc_match;
    logic       vblank_irq;
    logic       stat_irq;
    logic       line_done;
  } lsmt_res_t;

endpackage

>>> sv/lsmt_dot_alu.sv
// Shared dot balance adder/subtractor with borrow compare.
module lsmt_dot_alu #(
  parameter int BalW = 10
) (
  input  lsmt_pkg::alu_op_e op_i,
  input  logic [BalW-1:0]   a_i,
  input  logic [BalW-1:0]   b_i,
  output logic [BalW-1:0]   y_o,
  output logic              lt_o
);
  import lsmt_pkg::*;

  logic [BalW:0] diff;

  assign diff = {1'b0, a_i} - {1'b0, b_i};
  assign lt_o = diff[BalW];
  assign y_o  = (op_i == ALU_ADD) ? (a_i + b_i) : diff[BalW-1:0];

endmodule

>>> sv/lsmt_core.sv
// Line/mode sequencer: holds timing state and steps it one transition per cycle.
module lsmt_core #(
  parameter int DOTS_PER_LINE     = lsmt_pkg::DotsPerLineDef,
  parameter int VISIBLE_LINES     = lsmt_pkg::VisibleLinesDef,
  parameter int TOTAL_LINES       = lsmt_pkg::TotalLinesDef,
  parameter int OAM_DOTS          = lsmt_pkg::OamDotsDef,
  parameter int TRANSFER_MIN_DOTS = lsmt_pkg::TransferMinDotsDef,
  parameter int BalW              = $clog2(DOTS_PER_LINE + 256)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          dots_i,
  input  logic                lcd_on_i,
  input  logic [7:0]          lyc_i,
  input  logic [7:0]          scroll_x_i,
  input  logic [3:0]          stat_enables_i,
  input  logic                out_free_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output lsmt_pkg::lsmt_res_t res_o,
  output lsmt_pkg::alu_op_e   alu_op_o,
  output logic [BalW-1:0]     alu_a_o,
  output logic [BalW-1:0]     alu_b_o,
  input  logic [BalW-1:0]     alu_y_i,
  input  logic                alu_lt_i
);
  import lsmt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  localparam logic [BalW-1:0] OamLen  = BalW'(OAM_DOTS);
  localparam logic [BalW-1:0] LineLen = BalW'(DOTS_PER_LINE);
  localparam logic [7:0]      VisLine = 8'(VISIBLE_LINES);
  localparam logic [7:0]      TotLine = 8'(TOTAL_LINES);
  localparam logic [7:0]      VisWrap = 8'((VISIBLE_LINES + 1) % TOTAL_LINES);

  function automatic logic [BalW-1:0] xfer_len(input logic [2:0] fine);
    return BalW'(TRANSFER_MIN_DOTS) + BalW'(fine);
  endfunction

  function automatic logic [BalW-1:0] hblank_len(input logic [2:0] fine);
    int used;
    used = OAM_DOTS + TRANSFER_MIN_DOTS + int'(fine);
    if (used < DOTS_PER_LINE) return BalW'(DOTS_PER_LINE - used);
    return '0;
  endfunction

  state_e          state_q, state_d;
  logic [BalW-1:0] bal_q, bal_d;
  mode_e           seq_q, seq_d;
  mode_e           rep_q, rep_d;
  logic [7:0]      line_q, line_d;
  logic [2:0]      fine_q, fine_d;
  logic            lyc_flag_q, lyc_flag_d;
  logic            stat_lvl_q, stat_lvl_d;
  logic            vbl_q, vbl_d;
  logic            sirq_q, sirq_d;
  logic            done_q, done_d;
  logic [7:0]      lyc_q, lyc_d;
  logic [2:0]      scx_q, scx_d;
  logic [3:0]      en_q, en_d;

  always_comb begin
    logic       eval;
    logic       stop;
    logic       level;
    logic [7:0] line_inc;
    eval       = 1'b0;
    stop       = 1'b0;
    level      = 1'b0;
    line_inc   = line_q + 8'd1;
    state_d    = state_q;
    bal_d      = bal_q;
    seq_d      = seq_q;
    rep_d      = rep_q;
    line_d     = line_q;
    fine_d     = fine_q;
    lyc_flag_d = lyc_flag_q;
    stat_lvl_d = stat_lvl_q;
    vbl_d      = vbl_q;
    sirq_d     = sirq_q;
    done_d     = done_q;
    lyc_d      = lyc_q;
    scx_d      = scx_q;
    en_d       = en_q;
    alu_op_o   = ALU_SUB;
    alu_a_o    = bal_q;
    alu_b_o    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          vbl_d  = 1'b0;
          sirq_d = 1'b0;
          done_d = 1'b0;
          lyc_d  = lyc_i;
          scx_d  = scroll_x_i[2:0];
          en_d   = stat_enables_i;
          if (lcd_on_i) begin
            alu_op_o = ALU_ADD;
            alu_b_o  = BalW'(dots_i);
            bal_d    = alu_y_i;
            state_d  = (alu_y_i == '0) ? ST_DONE : ST_RUN;
          end else begin
            // Display off: report line 0 in HBLANK, keep the rest.
            line_d  = '0;
            rep_d   = MODE_HBLANK;
            state_d = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        if (line_q < VisLine) begin
          unique case (seq_q)
            MODE_OAM: begin
              alu_b_o = OamLen;
              if (alu_lt_i) begin
                stop = 1'b1;
              end else begin
                bal_d  = alu_y_i;
                fine_d = scx_q;
                seq_d  = MODE_XFER;
                rep_d  = MODE_XFER;
                eval   = 1'b1;
              end
            end
            MODE_XFER: begin
              alu_b_o = xfer_len(fine_q);
              if (alu_lt_i) begin
                stop = 1'b1;
              end else begin
                bal_d  = alu_y_i;
                done_d = 1'b1;
                seq_d  = MODE_HBLANK;
                rep_d  = MODE_HBLANK;
                eval   = 1'b1;
              end
            end
            default: begin
              alu_b_o = hblank_len(fine_q);
              if (alu_lt_i) begin
                stop = 1'b1;
              end else begin
                bal_d      = alu_y_i;
                line_d     = line_inc;
                lyc_flag_d = (line_inc == lyc_q);
                if (line_inc < VisLine) begin
                  seq_d = MODE_OAM;
                  rep_d = MODE_OAM;
                end
                eval = 1'b1;
              end
            end
          endcase
        end else if (line_q == VisLine && seq_q != MODE_VBLANK) begin
          // Enter VBLANK; the balance is untouched, so the next step follows.
          seq_d = MODE_VBLANK;
          rep_d = MODE_VBLANK;
          vbl_d = 1'b1;
          eval  = 1'b1;
        end else begin
          alu_b_o = LineLen;
          if (alu_lt_i) begin
            stop = 1'b1;
          end else begin
            bal_d = alu_y_i;
            if (line_q == VisLine) begin
              line_d = VisWrap;
            end else if (line_inc == TotLine) begin
              line_d = '0;
            end else begin
              line_d = line_inc;
            end
            lyc_flag_d = (line_d == lyc_q);
            if (line_d == '0) begin
              seq_d = MODE_OAM;
              rep_d = MODE_OAM;
            end
            eval = 1'b1;
          end
        end
        if (stop || bal_d == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (eval) begin
      level = (en_q[3] & lyc_flag_d) |
              (en_q[0] & (rep_d == MODE_HBLANK)) |
              (en_q[1] & (rep_d == MODE_VBLANK)) |
              (en_q[2] & (rep_d == MODE_OAM));
      sirq_d     = sirq_q | (level & ~stat_lvl_q);
      stat_lvl_d = level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bal_q      <= '0;
      seq_q      <= MODE_OAM;
      rep_q      <= MODE_HBLANK;
      line_q     <= '0;
      fine_q     <= '0;
      lyc_flag_q <= 1'b0;
      stat_lvl_q <= 1'b0;
      vbl_q      <= 1'b0;
      sirq_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      bal_q      <= bal_d;
      seq_q      <= seq_d;
      rep_q      <= rep_d;
      line_q     <= line_d;
      fine_q     <= fine_d;
      lyc_flag_q <= lyc_flag_d;
      stat_lvl_q <= stat_lvl_d;
      vbl_q      <= vbl_d;
      sirq_q     <= sirq_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lyc_q <= lyc_d;
    scx_q <= scx_d;
    en_q  <= en_d;
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.line        = line_q;
  assign res_o.mode        = rep_q;
  assign res_o.lyc_match   = lyc_flag_q;
  assign res_o.vblank_irq  = vbl_q;
  assign res_o.stat_irq    = sirq_q;
  assign res_o.line_done   = done_q;

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> bal_q != '0)
    else $error("sequencer stepping with an empty dot balance");

  a_xfer_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q == MODE_XFER |-> seq_q == MODE_XFER)
    else $error("transfer reported outside the transfer step");

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> state_q != ST_IDLE)
    else $error("accepted transfer did not start the sequencer");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_free_i) |=> state_q == ST_DONE && $stable(res_o))
    else $error("pending result lost while output is full");

endmodule

>>> sv/lcd_scanline_mode_timer_top.sv
// Top level of the LCD scanline mode timer: handshakes, output register, units.
//
// Input channel: each transfer carries a dot count since the previous tick,
// the display enable, LYC, SCX and the four STAT enables. Output channel:
// one result per input transfer with LY, the reported mode, the LYC flag,
// the VBLANK and STAT requests and the line_done marker.
//
// An accepted tick adds its dots to the balance in the accept cycle; the
// sequencer then steps through the mode transitions one at a time on the
// shared dot adder/subtractor until it finds the balance short or empties
// it exactly, and the result then moves into the output register. One item
// is in flight at a time, so a new tick is taken only after the last result
// has left the sequencer. A tick with the display off or an empty balance
// goes from the accept straight to a finished result.
//
// in_stall_o is high while the sequencer works or holds a finished result.
// When out_stall_i holds the output register, the next result waits in the
// sequencer, and a new tick is taken only after that one moves on.
// Reset clears the state to line 0, OAM sequence step, HBLANK reported,
// zero balance; no clearing pass is needed.
module lcd_scanline_mode_timer_top #(
  parameter int DOTS_PER_LINE     = lsmt_pkg::DotsPerLineDef,
  parameter int VISIBLE_LINES     = lsmt_pkg::VisibleLinesDef,
  parameter int TOTAL_LINES       = lsmt_pkg::TotalLinesDef,
  parameter int OAM_DOTS          = lsmt_pkg::OamDotsDef,
  parameter int TRANSFER_MIN_DOTS = lsmt_pkg::TransferMinDotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] dots_i,
  input  logic       lcd_on_i,
  input  logic [7:0] lyc_i,
  input  logic [7:0] scroll_x_i,
  input  logic [3:0] stat_enables_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] line_o,
  output logic [1:0] mode_o,
  output logic       lyc_match_o,
  output logic       vblank_irq_o,
  output logic       stat_irq_o,
  output logic       line_done_o
);
  import lsmt_pkg::*;

  // Balance must hold a line's worth of dots plus one full tick.
  localparam int BalW = $clog2(DOTS_PER_LINE + 256);

  logic            busy;
  logic            start;
  logic            res_valid;
  lsmt_res_t       res;
  logic            out_free;
  alu_op_e         alu_op;
  logic [BalW-1:0] alu_a;
  logic [BalW-1:0] alu_b;
  logic [BalW-1:0] alu_y;
  logic            alu_lt;
  logic            out_valid_q, out_valid_d;
  lsmt_res_t       out_q;

  assign in_stall_o = busy;
  assign start      = in_valid_i & ~busy;
  // Output slot is free when empty or being drained this cycle.
  assign out_free   = ~out_valid_q | ~out_stall_i;

  lsmt_dot_alu #(
    .BalW (BalW)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y),
    .lt_o (alu_lt)
  );

  lsmt_core #(
    .DOTS_PER_LINE     (DOTS_PER_LINE),
    .VISIBLE_LINES     (VISIBLE_LINES),
    .TOTAL_LINES       (TOTAL_LINES),
    .OAM_DOTS          (OAM_DOTS),
    .TRANSFER_MIN_DOTS (TRANSFER_MIN_DOTS),
    .BalW              (BalW)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .dots_i         (dots_i),
    .lcd_on_i       (lcd_on_i),
    .lyc_i          (lyc_i),
    .scroll_x_i     (scroll_x_i),
    .stat_enables_i (stat_enables_i),
    .out_free_i     (out_free),
    .busy_o         (busy),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .alu_op_o       (alu_op),
    .alu_a_o        (alu_a),
    .alu_b_o        (alu_b),
    .alu_y_i        (alu_y),
    .alu_lt_i       (alu_lt)
  );

  // Load a finished result when the slot frees; drop valid once drained.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload holds while stalled since it loads only on a free slot.
  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_o       = out_q.line;
  assign mode_o       = out_q.mode;
  assign lyc_match_o  = out_q.lyc_match;
  assign vblank_irq_o = out_q.vblank_irq;
  assign stat_irq_o   = out_q.stat_irq;
  assign line_done_o  = out_q.line_done;

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !res_valid)
    else $error("input taken while a result is still pending");

  a_result_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && out_free) |=> out_valid_o)
    else $error("finished result not presented on the output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_q))
    else $error("stalled result changed or dropped");

endmodule

>>> dv/lsmt_timing_checker.sv
// Checker for the LCD scanline mode timer: predicts each tick's result and compares.
`timescale 1ns / 100ps

module lsmt_timing_checker #(
  parameter int DOTS_PER_LINE     = lsmt_pkg::DotsPerLineDef,
  parameter int VISIBLE_LINES     = lsmt_pkg::VisibleLinesDef,
  parameter int TOTAL_LINES       = lsmt_pkg::TotalLinesDef,
  parameter int OAM_DOTS          = lsmt_pkg::OamDotsDef,
  parameter int TRANSFER_MIN_DOTS = lsmt_pkg::TransferMinDotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] dots_i,
  input  logic       lcd_on_i,
  input  logic [7:0] lyc_i,
  input  logic [7:0] scroll_x_i,
  input  logic [3:0] stat_enables_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] line_i,
  input  logic [1:0] mode_i,
  input  logic       lyc_match_i,
  input  logic       vblank_irq_i,
  input  logic       stat_irq_i,
  input  logic       line_done_i,
  output int         fail_count_o,
  output int         results_due_o
);
  import lsmt_pkg::*;

  // Shadow copy of the timer state.
  int unsigned dot_bal;
  mode_e       seq_q;
  mode_e       shown_q;
  logic [7:0]  ly_q;
  logic [2:0]  fine_scx_q;
  int unsigned xfer_len_q;
  logic        lyc_eq_q;
  logic        stat_lvl_q;

  lsmt_res_t   expected_timing[$];
  int          errs;

  // Recompute the combined STAT line, return its rising edge.
  function automatic logic stat_edge(logic [3:0] en);
    logic lvl;
    lvl = (en[3] && lyc_eq_q) ||
          (en[0] && shown_q == MODE_HBLANK) ||
          (en[1] && shown_q == MODE_VBLANK) ||
          (en[2] && shown_q == MODE_OAM);
    stat_edge  = lvl && !stat_lvl_q;
    stat_lvl_q = lvl;
  endfunction

  function automatic void enter_line(int unsigned nxt, logic [7:0] lyc);
    ly_q     = nxt[7:0];
    lyc_eq_q = (ly_q == lyc);
  endfunction

  function automatic lsmt_res_t predict_tick(logic [7:0] dots, logic on, logic [7:0] lyc,
                                             logic [7:0] scx, logic [3:0] en);
    lsmt_res_t   res;
    int unsigned hb;
    int unsigned used;
    logic        vbl;
    logic        sirq;
    logic        done;
    vbl  = 1'b0;
    sirq = 1'b0;
    done = 1'b0;
    if (!on) begin
      ly_q    = 8'd0;
      shown_q = MODE_HBLANK;
    end else begin
      dot_bal += dots;
      while (dot_bal > 0) begin
        if (ly_q < VISIBLE_LINES) begin
          if (seq_q == MODE_OAM) begin
            if (dot_bal < OAM_DOTS) break;
            dot_bal    -= OAM_DOTS;
            fine_scx_q  = scx[2:0];
            seq_q       = MODE_XFER;
            shown_q     = MODE_XFER;
            sirq       |= stat_edge(en);
          end else if (seq_q == MODE_XFER) begin
            xfer_len_q = TRANSFER_MIN_DOTS + fine_scx_q;
            if (dot_bal < xfer_len_q) break;
            dot_bal -= xfer_len_q;
            done     = 1'b1;
            seq_q    = MODE_HBLANK;
            shown_q  = MODE_HBLANK;
            sirq    |= stat_edge(en);
          end else begin
            used = OAM_DOTS + xfer_len_q;
            hb   = (used < DOTS_PER_LINE) ? DOTS_PER_LINE - used : 0;
            if (dot_bal < hb) break;
            dot_bal -= hb;
            enter_line(ly_q + 1, lyc);
            if (ly_q < VISIBLE_LINES) begin
              seq_q   = MODE_OAM;
              shown_q = MODE_OAM;
            end
            sirq |= stat_edge(en);
          end
        end else begin
          if (ly_q == VISIBLE_LINES && seq_q != MODE_VBLANK) begin
            seq_q   = MODE_VBLANK;
            shown_q = MODE_VBLANK;
            vbl     = 1'b1;
            sirq   |= stat_edge(en);
          end
          if (dot_bal < DOTS_PER_LINE) break;
          dot_bal -= DOTS_PER_LINE;
          enter_line((ly_q + 1) % TOTAL_LINES, lyc);
          if (ly_q == 0) begin
            seq_q   = MODE_OAM;
            shown_q = MODE_OAM;
          end
          sirq |= stat_edge(en);
        end
      end
    end
    res.line       = ly_q;
    res.mode       = shown_q;
    res.lyc_match  = lyc_eq_q;
    res.vblank_irq = vbl;
    res.stat_irq   = sirq;
    res.line_done  = done;
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lsmt_res_t want;
    if (!rst_ni) begin
      dot_bal    = 0;
      seq_q      = MODE_OAM;
      shown_q    = MODE_HBLANK;
      ly_q       = 8'd0;
      fine_scx_q = 3'd0;
      xfer_len_q = TRANSFER_MIN_DOTS;
      lyc_eq_q   = 1'b0;
      stat_lvl_q = 1'b0;
      errs       = 0;
      expected_timing.delete();
      fail_count_o  <= 0;
      results_due_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_timing.size() == 0) begin
          $display("%0t: unexpected result, line %0d mode %0d", $time, line_i, mode_i);
          errs++;
        end else begin
          want = expected_timing.pop_front();
          check_field("line",       want.line,       line_i);
          check_field("mode",       int'(want.mode), mode_i);
          check_field("lyc_match",  want.lyc_match,  lyc_match_i);
          check_field("vblank_irq", want.vblank_irq, vblank_irq_i);
          check_field("stat_irq",   want.stat_irq,   stat_irq_i);
          check_field("line_done",  want.line_done,  line_done_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_timing.push_back(predict_tick(dots_i, lcd_on_i, lyc_i, scroll_x_i,
                                               stat_enables_i));
      fail_count_o  <= errs;
      results_due_o <= expected_timing.size();
    end
  end

endmodule

>>> dv/lcd_scanline_mode_timer_top_test.sv
// Testbench top for the LCD scanline mode timer: stimulus, stall patterns and verdict.
`timescale 1ns / 100ps

module lcd_scanline_mode_timer_top_test;
  import lsmt_pkg::*;

  // Give up after this many cycles with no transfer on either channel.
  localparam int StallLimit   = 5000;
  localparam int ItemsPerPass = 370;
  localparam int LineDots     = DotsPerLineDef;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [7:0] dots_i         = 8'd0;
  logic       lcd_on_i       = 1'b0;
  logic [7:0] lyc_i          = 8'd0;
  logic [7:0] scroll_x_i     = 8'd0;
  logic [3:0] stat_enables_i = 4'd0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [7:0] line_o;
  logic [1:0] mode_o;
  logic       lyc_match_o;
  logic       vblank_irq_o;
  logic       stat_irq_o;
  logic       line_done_o;

  int         fail_count;
  int         results_due;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         quiet_cycles   = 0;
  // Dots taken while the display is on, modulo one line: the line phase.
  int         line_phase     = 0;
  // Last line number seen on the output, used to aim LYC near the beam.
  logic [7:0] seen_line      = 8'd0;

  always #5 clk_i = ~clk_i;

  lcd_scanline_mode_timer_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .dots_i         (dots_i),
    .lcd_on_i       (lcd_on_i),
    .lyc_i          (lyc_i),
    .scroll_x_i     (scroll_x_i),
    .stat_enables_i (stat_enables_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_o         (line_o),
    .mode_o         (mode_o),
    .lyc_match_o    (lyc_match_o),
    .vblank_irq_o   (vblank_irq_o),
    .stat_irq_o     (stat_irq_o),
    .line_done_o    (line_done_o)
  );

  lsmt_timing_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .dots_i         (dots_i),
    .lcd_on_i       (lcd_on_i),
    .lyc_i          (lyc_i),
    .scroll_x_i     (scroll_x_i),
    .stat_enables_i (stat_enables_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_i         (line_o),
    .mode_i         (mode_o),
    .lyc_match_i    (lyc_match_o),
    .vblank_irq_i   (vblank_irq_o),
    .stat_irq_i     (stat_irq_o),
    .line_done_i    (line_done_o),
    .fail_count_o   (fail_count),
    .results_due_o  (results_due)
  );

  // Receiver side: stall the output at the rate of the current pass.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Track the line on the output; sample mid-cycle so the value is settled.
  always @(negedge clk_i) begin
    if (out_valid_o && !out_stall_i) seen_line = line_o;
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Present one tick, idling first at the sender's rate, and hold it until
  // the transfer. Return right after the accepting edge.
  task automatic send_tick(input logic [7:0] dots, input logic on, input logic [7:0] lyc,
                           input logic [7:0] scx, input logic [3:0] en);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    dots_i         <= dots;
    lcd_on_i       <= on;
    lyc_i          <= lyc;
    scroll_x_i     <= scx;
    stat_enables_i <= en;
    do @(posedge clk_i); while (in_stall_o);
    if (on) line_phase = (line_phase + dots) % LineDots;
  endtask

  // Drop valid and hold off until every predicted result has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  // One random tick. Roughly a third of the ticks realign the dot count to
  // line boundaries and then advance by whole fractions of a line, so the
  // balance lands on zero at line ends (this also hits VBLANK entry with an
  // empty balance). The rest are mostly large, to sweep several frames.
  task automatic random_tick();
    int         pick;
    logic [7:0] dots;
    logic       on;
    logic [7:0] lyc;
    pick = $urandom_range(99);
    if (pick < 30) begin
      if (line_phase != 0)
        dots = (LineDots - line_phase > 255) ? 8'd255 : 8'(LineDots - line_phase);
      else
        case ($urandom_range(3))
          0:       dots = 8'd76;
          1:       dots = 8'd114;
          2:       dots = 8'd152;
          default: dots = 8'd228;
        endcase
    end else if (pick < 75) begin
      dots = 8'($urandom_range(128, 255));
    end else begin
      dots = 8'($urandom_range(0, 255));
    end
    // Keep the display on almost always, or VBLANK is never reached.
    on   = ($urandom_range(299) != 0);
    pick = $urandom_range(9);
    if (pick < 4)
      lyc = seen_line + 8'($urandom_range(0, 2));
    else if (pick < 8)
      lyc = 8'($urandom_range(0, TotalLinesDef - 1));
    else
      lyc = 8'($urandom_range(0, 255));
    send_tick(dots, on, lyc, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: walk the first line by hand, no idling.
    // Empty balance right after reset: nothing moves, flag stays clear.
    send_tick(8'd0,   1'b1, 8'd0,   8'd0,   4'h0);
    // Display off with everything at its maximum: dots are dropped.
    send_tick(8'd255, 1'b0, 8'd255, 8'd255, 4'hF);
    // One dot short of the end of OAM, then exactly at it; latch fine scroll 7.
    send_tick(8'd79,  1'b1, 8'd0,   8'd255, 4'h4);
    send_tick(8'd1,   1'b1, 8'd0,   8'd255, 4'h4);
    // Longest transfer is 179 dots: stop one short, then finish it.
    send_tick(8'd178, 1'b1, 8'd0,   8'd0,   4'h1);
    send_tick(8'd1,   1'b1, 8'd0,   8'd0,   4'h1);
    // HBLANK of exactly the rest of the line; line 1 matches LYC.
    send_tick(8'd197, 1'b1, 8'd1,   8'd0,   4'h8);
    send_tick(8'd255, 1'b1, 8'd2,   8'h55,  4'hF);
    send_tick(8'd255, 1'b1, 8'd3,   8'hAA,  4'h2);
    // Display off in the middle of a line keeps the sequence step.
    send_tick(8'd128, 1'b0, 8'd0,   8'd0,   4'hF);
    send_tick(8'd0,   1'b1, 8'd0,   8'd0,   4'hF);
    send_tick(8'd255, 1'b1, 8'hAA,  8'hAA,  4'hA);
    send_tick(8'd255, 1'b1, 8'h55,  8'h55,  4'h5);
    send_tick(8'd255, 1'b1, 8'd255, 8'd7,   4'h0);
    send_tick(8'd255, 1'b1, 8'd153, 8'd0,   4'hC);
    send_tick(8'd1,   1'b1, 8'd0,   8'd1,   4'h3);

    // Random passes: mostly receiver stalls, then mostly sender idles, then neither.
    for (int pass = 0; pass < 3; pass++) begin
      drain();
      send_idle_pct  <= (pass == 0) ? 28 : (pass == 1) ? 79 : 0;
      recv_stall_pct <= (pass == 0) ? 79 : (pass == 1) ? 28 : 0;
      for (int n = 0; n < ItemsPerPass; n++) begin
        if ($urandom_range(79) == 0) drain();
        random_tick();
      end
    end

    // Wait for the last results, then let the pipeline settle.
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && results_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lsmt_pkg.sv
sv/lsmt_dot_alu.sv
sv/lsmt_core.sv
sv/lcd_scanline_mode_timer_top.sv
dv/lsmt_timing_checker.sv
dv/lcd_scanline_mode_timer_top_test.sv
